[hw/rtl/hctp_pkg.sv]
`default_nettype none

package hctp_pkg;

  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned HEIGHT_W       = 32;
  localparam int unsigned COLOR_W        = 24;
  localparam int unsigned MAX_HEX_DIGITS = 6;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 24'hFFFFFF;

  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_X   = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LOW_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;

  // Largest magnitudes for a positive and a negative height.
  localparam logic [35:0] POS_LIMIT = 36'h07FFFFFFF;
  localparam logic [35:0] NEG_LIMIT = 36'h080000000;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_DIGITS = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_X      = 6'b001000,
    PH_HEX    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last_char;
  } char_word_t;

  typedef struct packed {
    logic                       valid_res;
    logic signed [HEIGHT_W-1:0] height;
    logic [COLOR_W-1:0]         color;
  } result_t;

  // {ok, value} for one ASCII hex digit
  function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hctp_parse.sv]
`default_nettype none

// Token state and the per-character update; builds the result for the last character.
module hctp_parse #(
  parameter int unsigned MAX_HEX_DIGITS = hctp_pkg::MAX_HEX_DIGITS
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              step,
  input  wire  hctp_pkg::char_word_t       word,
  input  wire  [hctp_pkg::COLOR_W-1:0]     default_color,
  output hctp_pkg::result_t                result
);
  import hctp_pkg::*;

  localparam int unsigned ACC_W = 4 * MAX_HEX_DIGITS;
  localparam int unsigned CNT_W = $clog2(MAX_HEX_DIGITS + 1);

  phase_t                parse_phase, parse_phase_next;
  logic                  negative, negative_next;
  logic [HEIGHT_W-1:0]   magnitude, magnitude_next;
  logic                  seen_digit, seen_digit_next;
  logic [ACC_W-1:0]      color_acc, color_acc_next;
  logic [CNT_W-1:0]      hex_count, hex_count_next;
  logic                  failed, failed_next;

  logic [CHAR_W-1:0]     c;
  logic                  do_height;
  logic                  is_digit;
  logic [4:0]            hex;
  logic [35:0]           mag_ext;
  logic [35:0]           product;
  logic [35:0]           limit;
  logic [31:0]           acc_ext;
  logic                  ok;

  assign c        = word.character;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign hex      = hex_nibble(c);
  assign mag_ext  = {4'b0, magnitude};
  assign product  = (mag_ext << 3) + (mag_ext << 1) + {32'b0, c[3:0]};
  assign limit    = negative ? NEG_LIMIT : POS_LIMIT;

  always_comb begin
    parse_phase_next = parse_phase;
    negative_next    = negative;
    magnitude_next   = magnitude;
    seen_digit_next  = seen_digit;
    color_acc_next   = color_acc;
    hex_count_next   = hex_count;
    failed_next      = failed;
    do_height        = 1'b0;

    unique case (parse_phase)
      PH_START: begin
        parse_phase_next = PH_DIGITS;
        if (c == CH_PLUS || c == CH_MINUS) begin
          negative_next = (c == CH_MINUS);
        end else begin
          do_height = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_height = 1'b1;
      end
      PH_ZERO: begin
        if (c == CH_ZERO) begin
          parse_phase_next = PH_X;
        end else begin
          failed_next      = 1'b1;
          parse_phase_next = PH_DONE;
        end
      end
      PH_X: begin
        if (c == CH_LOW_X || c == CH_UP_X) begin
          parse_phase_next = PH_HEX;
        end else begin
          failed_next      = 1'b1;
          parse_phase_next = PH_DONE;
        end
      end
      PH_HEX: begin
        if (c == CH_NEWLINE) begin
          if (hex_count == '0) begin
            failed_next = 1'b1;
          end
          parse_phase_next = PH_DONE;
        end else if (!hex[4]) begin
          failed_next = 1'b1;
        end else if (hex_count < CNT_W'(MAX_HEX_DIGITS)) begin
          color_acc_next = (color_acc << 4) | ACC_W'(hex[3:0]);
          hex_count_next = hex_count + 1'b1;
        end else begin
          failed_next = 1'b1;
        end
      end
      PH_DONE: begin
      end
      default: begin
        parse_phase_next = PH_START;
      end
    endcase

    if (do_height) begin
      if (is_digit) begin
        seen_digit_next = 1'b1;
        if (!failed) begin
          if (product > limit) begin
            failed_next = 1'b1;
          end else begin
            magnitude_next = product[HEIGHT_W-1:0];
          end
        end
      end else if (c == CH_COMMA) begin
        parse_phase_next = PH_ZERO;
      end else if (c == CH_NEWLINE) begin
        parse_phase_next = PH_DONE;
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  // Result as seen after this character
  assign acc_ext = 32'(color_acc_next);
  assign ok = !failed_next && seen_digit_next &&
              (parse_phase_next != PH_ZERO) && (parse_phase_next != PH_X) &&
              !((parse_phase_next == PH_HEX) && (hex_count_next == '0));

  always_comb begin
    result.valid_res = ok;
    result.height    = '0;
    result.color     = '0;
    if (ok) begin
      result.height = negative_next ? -magnitude_next : magnitude_next;
      result.color  = (hex_count_next != '0) ? acc_ext[COLOR_W-1:0] : default_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && word.last_char)) begin
      parse_phase <= PH_START;
      negative    <= 1'b0;
      magnitude   <= '0;
      seen_digit  <= 1'b0;
      color_acc   <= '0;
      hex_count   <= '0;
      failed      <= 1'b0;
    end else if (step) begin
      parse_phase <= parse_phase_next;
      negative    <= negative_next;
      magnitude   <= magnitude_next;
      seen_digit  <= seen_digit_next;
      color_acc   <= color_acc_next;
      hex_count   <= hex_count_next;
      failed      <= failed_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hctp_out_reg.sv]
`default_nettype none

// Result register toward the master side.
module hctp_out_reg (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 load,
  input  wire hctp_pkg::result_t result,
  input  wire                 m_tready,
  output logic                m_tvalid,
  output hctp_pkg::result_t   result_q
);
  import hctp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/height_color_token_parser_top.sv]
`default_nettype none
// A tlast word is registered at the input, then in the result register.
// One result word per token; one word per cycle while no tlast word waits.
// Words without tlast never wait on the master side.
// Reset (rst, synchronous, active high) clears all handshake and token state
// and sets default_color to 0xFFFFFF.

module height_color_token_parser_top #(
  parameter int unsigned MAX_HEX_DIGITS = hctp_pkg::MAX_HEX_DIGITS
) (
  input  wire         clk,
  input  wire         rst,
  // character stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] character
  input  wire         s_tlast,   // last_char
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [55:0] m_tdata,   // [31:0] height, [55:32] color
  output logic [0:0]  m_tuser,   // [0] valid_res
  // default color register
  input  wire         cfg_wen,
  input  wire  [23:0] cfg_wdata
);
  import hctp_pkg::*;

  // Input register: one character word.
  logic       in_valid;
  char_word_t in_word;
  logic       step;

  // Default color register; the user must write it only while the block is idle (the block does not enforce this).
  logic [COLOR_W-1:0] default_color;

  result_t result;
  result_t result_q;

  // The input stage moves on every cycle, except when it holds a last
  // character and the result register is still full and not being drained.
  assign step     = in_valid && (!in_word.last_char || !m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word.character <= s_tdata;
      in_word.last_char <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= DEFAULT_COLOR_RST;
    end else if (cfg_wen) begin
      default_color <= cfg_wdata;
    end
  end

  // Parse state update for one character per cycle, whenever step is high.
  hctp_parse #(
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .word         (in_word),
    .default_color(default_color),
    .result       (result)
  );

  // Result register; loaded when the token's last character is processed.
  hctp_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (step && in_word.last_char),
    .result  (result),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .result_q(result_q)
  );

  assign m_tdata = {result_q.color, result_q.height};
  assign m_tuser = result_q.valid_res;

endmodule

`default_nettype wire

[hw/rtl/hctp_checker.sv]
`default_nettype none

module hctp_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        s_tlast,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [55:0] m_tdata,
  input wire [0:0]  m_tuser
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // A rejected token reports zero height and color.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 56'd0)
    else $error("invalid token with nonzero payload");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A fresh result follows an accepted last character, via the input and result registers.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
    else $error("result without a last character");

endmodule

bind height_color_token_parser_top hctp_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tlast (s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire

[tb/hctp_token_checker.sv]
`timescale 1ns / 100ps

module hctp_token_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] character
  input  wire         s_tlast,   // last_char
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [55:0] m_tdata,   // [31:0] height, [55:32] color
  input  wire  [0:0]  m_tuser,   // [0] valid_res
  input  wire         cfg_wen,
  input  wire  [23:0] cfg_wdata,
  output int          mismatch_count,
  output int          pending
);
  import hctp_pkg::*;

  // token state as the parser should hold it
  phase_t             phase;
  logic               neg;
  logic               seen;
  logic               failed;
  logic [31:0]        mag;
  logic [31:0]        color_acc;
  int unsigned        hex_count;
  logic [COLOR_W-1:0] dflt_color;

  result_t expected_tokens[$];
  int      mismatches = 0;

  assign mismatch_count = mismatches;

  function automatic int hex_digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
    if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
    return -1;
  endfunction

  task automatic clear_token();
    phase     = PH_START;
    neg       = 1'b0;
    seen      = 1'b0;
    failed    = 1'b0;
    mag       = '0;
    color_acc = '0;
    hex_count = 0;
  endtask

  task automatic height_char(input logic [7:0] c);
    logic [35:0] grown;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      seen = 1'b1;
      if (!failed) begin
        grown = {4'b0, mag} * 36'd10 + 36'(c - CH_ZERO);
        // out of int range is flagged, never clamped
        if (grown > (neg ? NEG_LIMIT : POS_LIMIT)) begin
          failed = 1'b1;
        end else begin
          mag = grown[31:0];
        end
      end
    end else if (c == CH_COMMA) begin
      phase = PH_ZERO;
    end else if (c == CH_NEWLINE) begin
      phase = PH_DONE;
    end else begin
      failed = 1'b1;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    int h;
    case (phase)
      PH_START: begin
        phase = PH_DIGITS;
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg = (c == CH_MINUS);
        end else begin
          height_char(c);
        end
      end
      PH_DIGITS: height_char(c);
      PH_ZERO: begin
        if (c == CH_ZERO) begin
          phase = PH_X;
        end else begin
          failed = 1'b1;
          phase  = PH_DONE;
        end
      end
      PH_X: begin
        if (c == CH_LOW_X || c == CH_UP_X) begin
          phase = PH_HEX;
        end else begin
          failed = 1'b1;
          phase  = PH_DONE;
        end
      end
      PH_HEX: begin
        if (c == CH_NEWLINE) begin
          if (hex_count == 0) failed = 1'b1;
          phase = PH_DONE;
        end else begin
          h = hex_digit_value(c);
          if (h < 0 || hex_count >= MAX_HEX_DIGITS) begin
            failed = 1'b1;
          end else begin
            color_acc = (color_acc << 4) | 32'(h);
            hex_count++;
          end
        end
      end
      default: ;  // after newline: ignore until last
    endcase
  endtask

  function automatic result_t token_result();
    result_t r;
    logic    ok;
    ok = !failed && seen;
    if (phase == PH_ZERO || phase == PH_X) ok = 1'b0;
    if (phase == PH_HEX && hex_count == 0) ok = 1'b0;
    r.valid_res = ok;
    r.height    = '0;
    r.color     = '0;
    if (ok) begin
      r.height = neg ? -$signed(mag) : $signed(mag);
      r.color  = (hex_count > 0) ? color_acc[COLOR_W-1:0] : dflt_color;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      clear_token();
      dflt_color = DEFAULT_COLOR_RST;
      expected_tokens.delete();
    end else begin
      if (cfg_wen) dflt_color = cfg_wdata;

      // pop before push: a result always belongs to an older token
      if (m_tvalid && m_tready) begin
        got.valid_res = m_tuser[0];
        got.height    = m_tdata[31:0];
        got.color     = m_tdata[55:32];
        if (expected_tokens.size() == 0) begin
          $error("unexpected result word: valid_res=%0d height=%0d color=%06h",
                 got.valid_res, got.height, got.color);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
            mismatches++;
          end
          if (got.height !== want.height) begin
            $error("height: expected %0d, got %0d", want.height, got.height);
            mismatches++;
          end
          if (got.color !== want.color) begin
            $error("color: expected %06h, got %06h", want.color, got.color);
            mismatches++;
          end
        end
      end

      if (s_tvalid && s_tready) begin
        take_char(s_tdata);
        if (s_tlast) begin
          expected_tokens.push_back(token_result());
          clear_token();
        end
      end
    end
    pending <= expected_tokens.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

// Drives character words into the token parser, with random gaps on both
// sides, and leaves prediction and comparison to the checker. Verdict here.
module tb_top;
  import hctp_pkg::*;

  // Watchdog bound, several times the length of the slowest correct run.
  localparam int LIMIT       = 400000;
  localparam int PHASE_WORDS = 250;   // character words per random phase
  localparam int LONG_HOLD   = 600;   // receiver stall, long enough to back up the input

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_wen;
  logic [23:0] cfg_wdata;

  int fail_count;
  int pending;

  // idle control for the sender and the receiver
  bit tx_calm;    // sender offers back to back
  bit rx_calm;    // receiver always ready
  bit hold_req;   // receiver takes one long stall

  int unsigned words_sent;
  logic [7:0]  token_chars[$];
  string       hex_alphabet = "0123456789abcdefABCDEF";

  height_color_token_parser_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  hctp_token_checker token_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic append_text(input string t);
    foreach (t[i]) token_chars.push_back(t[i]);
  endtask

  task automatic add_noise(input int count);
    repeat (count) token_chars.push_back(8'($urandom_range(0, 255)));
  endtask

  // Optional sign, optional leading zero, then a magnitude that lands
  // small, anywhere in 32 bits, right at the int limits, or far past them.
  task automatic build_number();
    longint unsigned mag;
    case ($urandom_range(0, 7))
      0, 1: append_text("-");
      2:    append_text("+");
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: mag = $urandom_range(0, 9);
      1: mag = $urandom;
      2: mag = 64'd2147483638 + $urandom_range(0, 20);
      3: mag = {$urandom, $urandom} % 64'd100000000000;
      default: mag = $urandom_range(0, 99999);
    endcase
    if ($urandom_range(0, 9) == 0) append_text("0");
    append_text($sformatf("%0d", mag));
  endtask

  task automatic build_color(input int digits);
    append_text($urandom_range(0, 1) ? ",0x" : ",0X");
    repeat (digits) token_chars.push_back(hex_alphabet[$urandom_range(0, 21)]);
  endtask

  // Sends the collected characters, tlast on the final word. Each word
  // waits its drawn gap first; valid is only lowered when a gap is taken,
  // so back-to-back words never see a low/high pair in one step.
  task automatic send_token();
    int gap;
    foreach (token_chars[i]) begin
      gap = tx_calm ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= token_chars[i];
      s_tlast  <= (i == token_chars.size() - 1);
      do @(posedge clk); while (!s_tready);
      words_sent++;
    end
    token_chars.delete();
  endtask

  // Sender goes quiet until every expected result is back, then allows
  // for the block's input and result registers plus margin before anything else happens.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: own process, own gap per result word.
  initial begin : result_sink
    int gap;
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 18);
      if (hold_req) begin
        gap      = gap + LONG_HOLD;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    string       directed[24];
    logic [23:0] phase_color[4];
    int          n;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    hold_req   = 1'b0;
    words_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed tokens, run on the reset default color: int extremes, each
    // way a token goes invalid, newline handling, hex case mix.
    directed = '{"0", "+7", "-2147483648,0xFFFFFF", "2147483647,0x000000",
                 "2147483648", "-2147483649", "99999999999", "12a", "-", "+",
                 ",0x1", "5,1x1", "5,0y", "5,0xG", "5,0x1234567", "5,0x",
                 "5,0x\n", "7\nzz", "5,\n", "5,0", "3,0Xab12Cd", "\n",
                 "-0,0xf", "9\377"};
    foreach (directed[i]) begin
      append_text(directed[i]);
      send_token();
    end
    append_text("4");
    token_chars.push_back(8'h00);
    send_token();

    phase_color = '{24'h000000, 24'hFFFFFF, 24'($urandom), 24'h800001};

    for (int p = 0; p < 4; p++) begin
      drain();
      // register write only while the block is idle
      cfg_wen   <= 1'b1;
      cfg_wdata <= phase_color[p];
      @(posedge clk);
      cfg_wen   <= 1'b0;

      // 0: both sides random; 1: sender floods while receiver stalls long;
      // 2: no idling anywhere; 3: receiver always ready, sender random
      tx_calm  = (p == 1 || p == 2);
      rx_calm  = (p == 2 || p == 3);
      hold_req = (p == 1);

      while (words_sent < (p + 1) * PHASE_WORDS + 150) begin
        if ($urandom_range(0, 9) < 7) begin
          // well-formed, random content
          build_number();
          if ($urandom_range(0, 2) != 0) build_color($urandom_range(1, MAX_HEX_DIGITS));
          if ($urandom_range(0, 7) == 0) begin
            append_text("\n");
            add_noise($urandom_range(0, 3));
          end
        end else begin
          case ($urandom_range(0, 3))
            0: add_noise($urandom_range(1, 8));
            1: begin
              // one character overwritten by an arbitrary byte
              build_number();
              build_color($urandom_range(1, MAX_HEX_DIGITS));
              token_chars[$urandom_range(0, token_chars.size() - 1)] = 8'($urandom_range(0, 255));
            end
            2: begin
              // cut short anywhere, prefix included
              build_number();
              build_color($urandom_range(1, MAX_HEX_DIGITS));
              n = $urandom_range(1, token_chars.size() - 1);
              while (token_chars.size() > n) void'(token_chars.pop_back());
            end
            default: begin
              build_number();
              build_color($urandom_range(MAX_HEX_DIGITS + 1, MAX_HEX_DIGITS + 2));
            end
          endcase
        end
        send_token();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/hctp_pkg.sv
hw/rtl/hctp_parse.sv
hw/rtl/hctp_out_reg.sv
hw/rtl/height_color_token_parser_top.sv
hw/rtl/hctp_checker.sv
tb/hctp_token_checker.sv
tb/tb_top.sv
